/* design/loop_sample_player_crossfade_assert.svh */
// Assertion macros shared by the sample player RTL.
// Each macro checks one property on the rising clock edge, idle in reset.
`ifndef LOOP_SAMPLE_PLAYER_CROSSFADE_ASSERT_SVH
`define LOOP_SAMPLE_PLAYER_CROSSFADE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LSPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lspc: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define LSPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lspc: next-cycle check failed");

`endif

/* design/lspc_pkg.sv */
`default_nettype none

package lspc_pkg;

  // Field widths of the transaction payloads.
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned LEN_W   = 21;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned WORD_W  = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUBLISH   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TRANSPORT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REWIND    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK      = 3'd4;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_RATE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RAMP  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FADE  = 2'd2;

  // Register reset values.
  localparam logic [RATE_W-1:0] RATE_RST = 20'd65536;
  localparam logic [15:0]       RAMP_RST = 16'd124;
  localparam logic [15:0]       FADE_RST = 16'd352;

  // Unity gain in Q1.15.
  localparam logic [15:0] GAIN_UNITY = 16'd32768;

  // Serial divider: dividend and divisor widths, step counter width.
  localparam int unsigned DV_W  = 33;
  localparam int unsigned DEN_W = 21;
  localparam int unsigned CNT_W = 6;

  // Arithmetic right shift by k that rounds to nearest, ties away from zero.
  function automatic logic signed [39:0] rshr(input logic signed [39:0] x, input int k);
    logic [39:0] mag;
    mag = (x < 0) ? 40'(-x) : 40'(x);
    mag = (mag + (40'd1 << (k - 1))) >> k;
    return (x < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Linear interpolation between two samples at a Q.16 fraction.
  function automatic logic signed [SMP_W-1:0] interp_f(input logic signed [SMP_W-1:0] s0,
                                                      input logic signed [SMP_W-1:0] s1,
                                                      input logic [FRAC_W-1:0] fr);
    logic signed [34:0] w0;
    logic signed [34:0] w1;
    logic signed [34:0] acc;
    logic signed [39:0] r;
    w0  = 35'sd65536 - $signed({19'd0, fr});
    w1  = $signed({19'd0, fr});
    acc = 35'(s0) * w0 + 35'(s1) * w1;
    r   = rshr(40'(acc), 16);
    return r[SMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/loop_sample_player_crossfade.sv */
`default_nettype none
// Looping stereo sample player with linear interpolation and take crossfade.
// Input channel (in_valid_i / in_stall_o) carries requests: write a frame into
// a take, publish a take as live with its length, set play or stop, rewind, or
// tick. Only a tick yields a transaction on the output channel (out_valid_o /
// out_stall_i); the other requests finish in the cycle they are accepted.
// The user must write configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) only
// while idle; the block itself does not enforce it. A tick uses the shared
// serial divider: one run for the live playhead wrap, and with a crossfade
// active one more for each channel mix; with a non-empty old take also one
// for the old playhead wrap and one when the old playhead lies beyond the
// old take length. The take memory has one read port; a tick makes 4 reads.
// An empty live take gives an all-zero result.
// While the output register is stalled, a finished tick waits in its last
// state and no new request is taken. Reset clears the transport, gain, fade
// and take lengths; take memory contents are undefined until written.
`include "loop_sample_player_crossfade_assert.svh"

module loop_sample_player_crossfade #(
  parameter int unsigned TAKE_DEPTH  = 1048576,
  parameter int unsigned TAKE_COUNT  = 2,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lspc_pkg::CIDX_W-1:0]      cfg_idx_i,
  input  wire logic [lspc_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [lspc_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic                             take_slot_i,
  input  wire logic [lspc_pkg::FRAME_W-1:0]     frame_addr_i,
  input  wire logic signed [lspc_pkg::SMP_W-1:0] sample_left_i,
  input  wire logic signed [lspc_pkg::SMP_W-1:0] sample_right_i,
  input  wire logic [lspc_pkg::LEN_W-1:0]       take_length_i,
  input  wire logic                             play_on_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic signed [lspc_pkg::SMP_W-1:0] out_left_o,
  output      logic signed [lspc_pkg::SMP_W-1:0] out_right_o,
  output      logic [lspc_pkg::FRAME_W-1:0]     head_frame_o,
  output      logic                             head_valid_o
);
  import lspc_pkg::*;

  localparam int unsigned MEM_DEPTH = TAKE_COUNT * TAKE_DEPTH;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned SLOT_W    = (TAKE_COUNT > 1) ? $clog2(TAKE_COUNT) : 1;
  localparam int unsigned OBITS     = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

  typedef enum logic [4:0] {
    S_IDLE, S_FMOD, S_FMODW, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_INTERP,
    S_XF, S_XFW, S_GAIN, S_ADV, S_ADVW, S_FADV, S_FADVW, S_OUT
  } state_e;

  // Saturate to the output sample range.
  function automatic logic signed [SMP_W-1:0] sat_o(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = (40'sd1 <<< (OBITS - 1)) - 40'sd1;
    lo = -hi - 40'sd1;
    if (v > hi) return hi[SMP_W-1:0];
    if (v < lo) return lo[SMP_W-1:0];
    return v[SMP_W-1:0];
  endfunction

  // Frame address in the flat take memory.
  function automatic logic [AW-1:0] maddr(input logic [SLOT_W-1:0] s,
                                         input logic [LEN_W-1:0] idx);
    return AW'(s) * AW'(TAKE_DEPTH) + AW'(idx);
  endfunction

  state_e state_q;

  // Configuration registers.
  logic [RATE_W-1:0] rate_q;
  logic [15:0]       ramp_q;
  logic [15:0]       ffr_q;

  // Player state.
  logic [LEN_W-1:0]  tf_q [TAKE_COUNT];
  logic [LEN_W-1:0]  live_len_q;
  logic [SLOT_W-1:0] live_slot_q;
  logic              live_valid_q;
  logic [LEN_W-1:0]  head_whole_q;
  logic [FRAC_W-1:0] head_frac_q;
  logic              fade_active_q;
  logic [SLOT_W-1:0] fade_slot_q;
  logic [LEN_W-1:0]  fade_whole_q;
  logic [FRAC_W-1:0] fade_frac_q;
  logic [15:0]       fade_count_q;
  logic [15:0]       gain_q;
  logic              play_q;

  // Per-tick working registers.
  logic [LEN_W-1:0]        old_len_q;
  logic [15:0]             span_q;
  logic                    zero_q;
  logic                    ch_q;
  logic                    xf_neg_q;
  logic [WORD_W-1:0]       lv0_q, lv1_q, fd0_q, fd1_q;
  logic signed [SMP_W-1:0] live_v_q [2];
  logic signed [SMP_W-1:0] fade_v_q [2];
  logic signed [SMP_W-1:0] mix_q [2];
  logic signed [SMP_W-1:0] res_q [2];

  // Output register.
  logic                    out_valid_q;
  logic signed [SMP_W-1:0] out_left_q, out_right_q;
  logic [FRAME_W-1:0]      head_frame_q;
  logic                    head_valid_q;

  // Take memory.
  logic [WORD_W-1:0] mem_q [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  // Serial divider.
  logic             div_start;
  logic [DV_W-1:0]  div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_busy_q;
  logic             div_done_q;
  logic [CNT_W-1:0] div_cnt_q;
  logic [DV_W-1:0]  div_quo_q;
  logic [DEN_W-1:0] div_rem_q;
  logic [DEN_W-1:0] div_dq;
  logic [DEN_W:0]   div_trial;
  logic             div_ge;

  logic in_acc;
  logic [SLOT_W-1:0] in_slot;
  logic [LEN_W-1:0]  pub_len;
  logic [15:0]       span;
  logic [15:0]       gain_next;
  logic [16:0]       tgt;
  logic [LEN_W-1:0]  live_i1, fade_i1;
  logic [16:0]       adv_f, fadv_f;
  logic [21:0]       adv_w, fadv_w;
  logic signed [34:0] xf_x;
  logic [34:0]        xf_mag;
  logic               out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_slot  = SLOT_W'(take_slot_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign out_left_o   = out_left_q;
  assign out_right_o  = out_right_q;
  assign head_frame_o = head_frame_q;
  assign head_valid_o = head_valid_q;

  // Published length, capped at the take depth.
  assign pub_len = ({1'b0, take_length_i} > 22'(TAKE_DEPTH)) ? LEN_W'(TAKE_DEPTH) : take_length_i;

  // Crossfade span, with zero read as one.
  assign span = (ffr_q == 16'd0) ? 16'd1 : ffr_q;

  // Gain ramp one step toward the transport target.
  always_comb begin
    tgt = play_q ? {1'b0, GAIN_UNITY} : 17'd0;
    gain_next = gain_q;
    if ({1'b0, gain_q} < tgt) begin
      gain_next = ((tgt - {1'b0, gain_q}) > {1'b0, ramp_q}) ? gain_q + ramp_q : tgt[15:0];
    end else if ({1'b0, gain_q} > tgt) begin
      gain_next = (({1'b0, gain_q} - tgt) > {1'b0, ramp_q}) ? gain_q - ramp_q : tgt[15:0];
    end
  end

  // Neighbor frame indexes, wrapping at the loop end.
  assign live_i1 = ({1'b0, head_whole_q} + 22'd1 >= {1'b0, live_len_q}) ? '0 : head_whole_q + 1'b1;
  assign fade_i1 = ({1'b0, fade_whole_q} + 22'd1 >= {1'b0, old_len_q}) ? '0 : fade_whole_q + 1'b1;

  // Playhead advance before the wrap.
  assign adv_f  = {1'b0, head_frac_q} + {1'b0, rate_q[FRAC_W-1:0]};
  assign adv_w  = {1'b0, head_whole_q} + 22'(rate_q[RATE_W-1:FRAC_W]) + 22'(adv_f[16]);
  assign fadv_f = {1'b0, fade_frac_q} + {1'b0, rate_q[FRAC_W-1:0]};
  assign fadv_w = {1'b0, fade_whole_q} + 22'(rate_q[RATE_W-1:FRAC_W]) + 22'(fadv_f[16]);

  // Crossfade mix numerator for the current channel.
  assign xf_x = 35'(live_v_q[ch_q]) * $signed({19'd0, fade_count_q})
              + 35'(fade_v_q[ch_q]) * $signed({19'd0, span_q - fade_count_q});
  assign xf_mag = (xf_x < 0) ? 35'(-xf_x) : 35'(xf_x);

  // Memory read address and divider requests by state.
  always_comb begin
    mem_raddr = maddr(live_slot_q, head_whole_q);
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_RD1:   mem_raddr = maddr(live_slot_q, live_i1);
      S_RD2:   mem_raddr = maddr(fade_slot_q, fade_whole_q);
      S_RD3:   mem_raddr = maddr(fade_slot_q, fade_i1);
      S_FMOD: begin
        div_start = fade_active_q && (old_len_q != '0) && (fade_whole_q >= old_len_q);
        div_num   = DV_W'(fade_whole_q);
        div_den   = old_len_q;
      end
      S_XF: begin
        div_start = 1'b1;
        div_num   = DV_W'(xf_mag) + DV_W'(span_q >> 1);
        div_den   = DEN_W'(span_q);
      end
      S_ADV: begin
        div_start = 1'b1;
        div_num   = DV_W'(adv_w);
        div_den   = live_len_q;
      end
      S_FADV: begin
        div_start = fade_active_q && (old_len_q != '0);
        div_num   = DV_W'(fadv_w);
        div_den   = old_len_q;
      end
      default: ;
    endcase
  end

  // Frame writes come straight from an accepted write transaction whose address lies inside the take.
  assign mem_we    = in_acc && (req_type_i == REQ_WRITE) && ({2'b00, frame_addr_i} < 22'(TAKE_DEPTH));
  assign mem_waddr = maddr(in_slot, LEN_W'(frame_addr_i));
  always_comb begin
    logic signed [SMP_W-1:0] sl;
    logic signed [SMP_W-1:0] sr;
    sl = sat_o(40'(sample_left_i));
    sr = sat_o(40'(sample_right_i));
    mem_wdata = {sr, sl};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Restoring divider, one quotient bit per cycle.
  assign div_trial = {div_rem_q, div_quo_q[DV_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_dq};

  logic [DEN_W-1:0] div_den_q;
  assign div_dq = div_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
      div_quo_q  <= '0;
      div_rem_q  <= '0;
      div_den_q  <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= CNT_W'(DV_W);
        div_quo_q  <= div_num;
        div_rem_q  <= '0;
        div_den_q  <= div_den;
      end else if (div_busy_q) begin
        div_quo_q <= {div_quo_q[DV_W-2:0], div_ge};
        div_rem_q <= div_ge ? DEN_W'(div_trial - {1'b0, div_dq}) : div_trial[DEN_W-1:0];
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == CNT_W'(1)) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  // Control sequencer, player state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rate_q        <= RATE_RST;
      ramp_q        <= RAMP_RST;
      ffr_q         <= FADE_RST;
      for (int i = 0; i < TAKE_COUNT; i++) tf_q[i] <= '0;
      live_len_q    <= '0;
      live_slot_q   <= '0;
      live_valid_q  <= 1'b0;
      head_whole_q  <= '0;
      head_frac_q   <= '0;
      fade_active_q <= 1'b0;
      fade_slot_q   <= '0;
      fade_whole_q  <= '0;
      fade_frac_q   <= '0;
      fade_count_q  <= '0;
      gain_q        <= '0;
      play_q        <= 1'b0;
      old_len_q     <= '0;
      span_q        <= 16'd1;
      zero_q        <= 1'b0;
      ch_q          <= 1'b0;
      xf_neg_q      <= 1'b0;
      lv0_q         <= '0;
      lv1_q         <= '0;
      fd0_q         <= '0;
      fd1_q         <= '0;
      for (int c = 0; c < 2; c++) begin
        live_v_q[c] <= '0;
        fade_v_q[c] <= '0;
        mix_q[c]    <= '0;
        res_q[c]    <= '0;
      end
      out_valid_q   <= 1'b0;
      out_left_q    <= '0;
      out_right_q   <= '0;
      head_frame_q  <= '0;
      head_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Configuration writes.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RATE: rate_q <= cfg_wdata_i;
          CFG_RAMP: ramp_q <= cfg_wdata_i[15:0];
          CFG_FADE: ffr_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (req_type_i)
              REQ_PUBLISH: begin
                if (live_valid_q && (in_slot != live_slot_q) && (gain_q != '0)) begin
                  fade_active_q <= 1'b1;
                  fade_slot_q   <= live_slot_q;
                  fade_whole_q  <= head_whole_q;
                  fade_frac_q   <= head_frac_q;
                  fade_count_q  <= '0;
                end
                tf_q[in_slot] <= pub_len;
                live_len_q    <= pub_len;
                live_slot_q   <= in_slot;
                live_valid_q  <= 1'b1;
                if ((pub_len == '0) || (head_whole_q >= pub_len)) begin
                  head_whole_q <= '0;
                  head_frac_q  <= '0;
                end
              end
              REQ_TRANSPORT: play_q <= play_on_i;
              REQ_REWIND: begin
                head_whole_q  <= '0;
                head_frac_q   <= '0;
                fade_active_q <= 1'b0;
              end
              REQ_TICK: begin
                if (!live_valid_q || (live_len_q == '0)) begin
                  zero_q  <= 1'b1;
                  state_q <= S_OUT;
                end else begin
                  zero_q    <= 1'b0;
                  gain_q    <= gain_next;
                  span_q    <= span;
                  old_len_q <= tf_q[fade_slot_q];
                  if (fade_active_q && (fade_count_q >= span)) begin
                    fade_active_q <= 1'b0;
                  end
                  state_q <= S_FMOD;
                end
              end
              default: ;
            endcase
          end
        end
        S_FMOD: state_q <= div_start ? S_FMODW : S_RD0;
        S_FMODW: begin
          if (div_done_q) begin
            fade_whole_q <= div_rem_q;
            state_q      <= S_RD0;
          end
        end
        S_RD0: state_q <= S_RD1;
        S_RD1: begin
          lv0_q   <= rdata_q;
          state_q <= S_RD2;
        end
        S_RD2: begin
          lv1_q   <= rdata_q;
          state_q <= S_RD3;
        end
        S_RD3: begin
          fd0_q   <= rdata_q;
          state_q <= S_RD4;
        end
        S_RD4: begin
          fd1_q   <= rdata_q;
          state_q <= S_INTERP;
        end
        S_INTERP: begin
          live_v_q[0] <= interp_f(lv0_q[15:0], lv1_q[15:0], head_frac_q);
          live_v_q[1] <= interp_f(lv0_q[31:16], lv1_q[31:16], head_frac_q);
          fade_v_q[0] <= (old_len_q == '0) ? '0 : interp_f(fd0_q[15:0], fd1_q[15:0], fade_frac_q);
          fade_v_q[1] <= (old_len_q == '0) ? '0 :
                         interp_f(fd0_q[31:16], fd1_q[31:16], fade_frac_q);
          mix_q[0]    <= interp_f(lv0_q[15:0], lv1_q[15:0], head_frac_q);
          mix_q[1]    <= interp_f(lv0_q[31:16], lv1_q[31:16], head_frac_q);
          ch_q        <= 1'b0;
          state_q     <= fade_active_q ? S_XF : S_GAIN;
        end
        S_XF: begin
          xf_neg_q <= (xf_x < 0);
          state_q  <= S_XFW;
        end
        S_XFW: begin
          if (div_done_q) begin
            mix_q[ch_q] <= xf_neg_q ? -$signed(div_quo_q[SMP_W-1:0]) : $signed(div_quo_q[SMP_W-1:0]);
            if (!ch_q) begin
              ch_q    <= 1'b1;
              state_q <= S_XF;
            end else begin
              state_q <= S_GAIN;
            end
          end
        end
        S_GAIN: begin
          for (int c = 0; c < 2; c++) begin
            res_q[c] <= sat_o(rshr(40'(35'(mix_q[c]) * $signed({19'd0, gain_q})), 15));
          end
          state_q <= S_ADV;
        end
        S_ADV: state_q <= S_ADVW;
        S_ADVW: begin
          if (div_done_q) begin
            head_whole_q <= div_rem_q;
            head_frac_q  <= adv_f[FRAC_W-1:0];
            state_q      <= S_FADV;
          end
        end
        S_FADV: begin
          if (!fade_active_q) begin
            state_q <= S_OUT;
          end else if (div_start) begin
            state_q <= S_FADVW;
          end else begin
            fade_whole_q <= '0;
            fade_frac_q  <= '0;
            fade_count_q <= fade_count_q + 1'b1;
            if (fade_count_q + 1'b1 >= span_q) fade_active_q <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_FADVW: begin
          if (div_done_q) begin
            fade_whole_q <= div_rem_q;
            fade_frac_q  <= fadv_f[FRAC_W-1:0];
            fade_count_q <= fade_count_q + 1'b1;
            if (fade_count_q + 1'b1 >= span_q) fade_active_q <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (zero_q) begin
              out_left_q   <= '0;
              out_right_q  <= '0;
              head_frame_q <= '0;
              head_valid_q <= 1'b0;
            end else begin
              out_left_q  <= res_q[0];
              out_right_q <= res_q[1];
              if (!play_q && (gain_q == '0)) begin
                head_whole_q <= '0;
                head_frac_q  <= '0;
                head_frame_q <= '0;
                head_valid_q <= 1'b0;
              end else begin
                head_frame_q <= head_whole_q[FRAME_W-1:0];
                head_valid_q <= 1'b1;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The playhead stays inside the live take between transactions.
  `LSPC_ASSERT_IMP(a_head_in_take, (state_q == S_IDLE) && live_valid_q && (live_len_q != '0), head_whole_q < live_len_q)
  // A result is only produced from the output state.
  `LSPC_ASSERT_NXT(a_out_from_state, (state_q != S_OUT) && !out_valid_q, !out_valid_q)
  // The divider is never restarted while it runs.
  `LSPC_ASSERT_IMP(a_div_free, div_start, !div_busy_q)
  // The gain never exceeds unity.
  `LSPC_ASSERT_IMP(a_gain_range, 1'b1, gain_q <= GAIN_UNITY)

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import lspc_pkg::*;

  localparam int unsigned DEPTH = 1048576;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // Block ports.
  logic                cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i = '0;
  logic                take_slot_i = 1'b0;
  logic [FRAME_W-1:0]  frame_addr_i = '0;
  logic signed [SMP_W-1:0] sample_left_i = '0;
  logic signed [SMP_W-1:0] sample_right_i = '0;
  logic [LEN_W-1:0]    take_length_i = '0;
  logic                play_on_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [SMP_W-1:0] out_left_o;
  logic signed [SMP_W-1:0] out_right_o;
  logic [FRAME_W-1:0]  head_frame_o;
  logic                head_valid_o;

  loop_sample_player_crossfade dut (.*);

  // One output frame as the player produces it.
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [19:0]        frame;
    logic               valid;
  } frame_out_t;

  frame_out_t frames_due[$];

  // Shadow of the player state.
  logic [31:0] mem_shadow [int unsigned];
  logic [20:0] len_sh [2];
  logic        live_sh, live_ok_sh;
  logic [19:0] head_w_sh, fhead_w_sh;
  logic [15:0] head_f_sh, fhead_f_sh;
  logic        fade_on_sh, fade_take_sh;
  int unsigned fade_cnt_sh, gain_sh;
  logic        play_sh;
  logic [19:0] rate_sh;
  logic [15:0] ramp_sh, fade_len_sh;

  // Frames known to be written, per take, so only written frames are ever read.
  int unsigned written_top [2];

  int unsigned mismatches = 0;
  int unsigned watchdog = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          timed_out = 0;

  function automatic longint round_div(longint x, longint d);
    if (x >= 0) return (x + d / 2) / d;
    return -((-x + d / 2) / d);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint read_smp(logic take, logic [19:0] idx, int ch);
    logic [31:0] w;
    int unsigned key;
    key = {11'd0, take, idx};
    w = mem_shadow.exists(key) ? mem_shadow[key] : 32'd0;
    return ch ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
  endfunction

  function automatic longint lerp_take(logic take, logic [19:0] whole, logic [15:0] frac,
                                       int unsigned len, int ch);
    logic [19:0] nxt;
    nxt = (whole + 1 >= len) ? 20'd0 : whole + 20'd1;
    return round_div(read_smp(take, whole, ch) * (65536 - frac)
                     + read_smp(take, nxt, ch) * frac, 65536);
  endfunction

  task automatic step_head(ref logic [19:0] whole, ref logic [15:0] frac, input int unsigned len);
    int unsigned f, w;
    f = frac + rate_sh[15:0];
    w = whole + rate_sh[19:16] + (f >> 16);
    frac = f[15:0];
    whole = (len != 0) ? 20'(w % len) : 20'd0;
    if (len == 0) frac = '0;
  endtask

  task automatic player_reset();
    len_sh = '{21'd0, 21'd0};
    live_sh = 0; live_ok_sh = 0;
    head_w_sh = 0; head_f_sh = 0;
    fade_on_sh = 0; fade_take_sh = 0; fhead_w_sh = 0; fhead_f_sh = 0;
    fade_cnt_sh = 0; gain_sh = 0; play_sh = 0;
    rate_sh = RATE_RST; ramp_sh = RAMP_RST; fade_len_sh = FADE_RST;
  endtask

  // Advances the shadow by one request and queues the frame a tick yields.
  task automatic play_request(logic [2:0] req, logic take, logic [19:0] addr,
                              logic [15:0] sl, logic [15:0] sr, logic [20:0] tlen,
                              logic pon);
    int unsigned len, target, span, oldlen;
    longint v, ov;
    frame_out_t r;
    logic [15:0] chv [2];
    case (req)
      REQ_WRITE: begin
        mem_shadow[{11'd0, take, addr}] = {sr, sl};
      end
      REQ_PUBLISH: begin
        len = (tlen > DEPTH) ? DEPTH : tlen;
        if (live_ok_sh && take != live_sh && gain_sh > 0) begin
          fade_on_sh = 1; fade_take_sh = live_sh;
          fhead_w_sh = head_w_sh; fhead_f_sh = head_f_sh; fade_cnt_sh = 0;
        end
        len_sh[take] = len;
        live_sh = take; live_ok_sh = 1;
        if (len == 0 || head_w_sh >= len) begin
          head_w_sh = 0; head_f_sh = 0;
        end
      end
      REQ_TRANSPORT: play_sh = pon;
      REQ_REWIND: begin
        head_w_sh = 0; head_f_sh = 0; fade_on_sh = 0;
      end
      REQ_TICK: begin
        len = live_ok_sh ? len_sh[live_sh] : 0;
        target = play_sh ? 32768 : 0;
        span = (fade_len_sh != 0) ? fade_len_sh : 1;
        oldlen = 0;
        if (len == 0) begin
          frames_due.push_back('0);
          return;
        end
        if (gain_sh < target)
          gain_sh = (target - gain_sh > ramp_sh) ? gain_sh + ramp_sh : target;
        else if (gain_sh > target)
          gain_sh = (gain_sh - target > ramp_sh) ? gain_sh - ramp_sh : target;
        if (head_w_sh >= len) head_w_sh = 20'(head_w_sh % len);
        if (fade_on_sh && fade_cnt_sh >= span) fade_on_sh = 0;
        if (fade_on_sh) oldlen = len_sh[fade_take_sh];
        for (int ch = 0; ch < 2; ch++) begin
          v = lerp_take(live_sh, head_w_sh, head_f_sh, len, ch);
          if (fade_on_sh) begin
            ov = 0;
            if (oldlen != 0)
              ov = lerp_take(fade_take_sh, 20'(fhead_w_sh % oldlen), fhead_f_sh, oldlen, ch);
            v = round_div(v * fade_cnt_sh + ov * (span - fade_cnt_sh), span);
          end
          chv[ch] = 16'(clamp16(round_div(v * gain_sh, 32768)));
        end
        step_head(head_w_sh, head_f_sh, len);
        if (fade_on_sh) begin
          step_head(fhead_w_sh, fhead_f_sh, oldlen);
          fade_cnt_sh++;
          if (fade_cnt_sh >= span) fade_on_sh = 0;
        end
        r.left = chv[0]; r.right = chv[1];
        if (!play_sh && gain_sh == 0) begin
          head_w_sh = 0; head_f_sh = 0;
          r.frame = 0; r.valid = 0;
        end else begin
          r.frame = head_w_sh; r.valid = 1;
        end
        frames_due.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Drives one transaction at the falling edge and holds it until accepted.
  task automatic send_request(logic [2:0] req, logic take, logic [19:0] addr,
                              logic [15:0] sl, logic [15:0] sr, logic [20:0] tlen,
                              logic pon);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    req_type_i = req; take_slot_i = take; frame_addr_i = addr;
    sample_left_i = sl; sample_right_i = sr; take_length_i = tlen; play_on_i = pon;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    play_request(req, take, addr, sl, sr, tlen, pon);
    if (req == REQ_WRITE && addr < written_top[take] + 1 && addr == written_top[take])
      written_top[take]++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Waits for all frames, then long enough for any silent request to finish.
  task automatic drain();
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_RATE: rate_sh = val;
      CFG_RAMP: ramp_sh = val[15:0];
      CFG_FADE: fade_len_sh = val[15:0];
      default: ;
    endcase
  endtask

  // Fills a take with consecutive frames from its first unwritten frame up to n.
  task automatic fill_take(logic take, int unsigned n);
    for (int unsigned a = written_top[take]; a < n; a++)
      send_request(REQ_WRITE, take, 20'(a), 16'($urandom), 16'($urandom), '0, 0);
  endtask

  // Random request over well-formed content; lengths never exceed written frames.
  task automatic random_request();
    int unsigned pick;
    logic take;
    take = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 55)
      send_request(REQ_TICK, take, 20'($urandom), 16'($urandom), 16'($urandom), '0, 0);
    else if (pick < 67)
      send_request(REQ_WRITE, take, 20'($urandom_range(written_top[take])),
                   16'($urandom), 16'($urandom), '0, 0);
    else if (pick < 70)
      send_request(REQ_WRITE, take, 20'($urandom_range(20'hFFFFF, 20'hF0000)),
                   16'($urandom), 16'($urandom), '0, 0);
    else if (pick < 80)
      send_request(REQ_PUBLISH, take, '0, '0, '0,
                   21'($urandom_range(written_top[take])), 0);
    else if (pick < 91)
      send_request(REQ_TRANSPORT, take, '0, '0, '0, '0, ($urandom_range(3) != 0));
    else if (pick < 95)
      send_request(REQ_REWIND, take, '0, '0, '0, '0, 0);
    else
      send_request(3'($urandom_range(7, 5)), take, 20'($urandom), 16'($urandom),
                   16'($urandom), 21'($urandom), $urandom_range(1));
  endtask

  // Output side: random stall and checking against the oldest expectation.
  always @(negedge clk_i)
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    frame_out_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_left_o, out_right_o, head_frame_o, head_valid_o};
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output frame %p", got);
      end else begin
        want = frames_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("frame mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      watchdog <= 0;
    else if (in_valid_i || frames_due.size() != 0)
      watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("simulation failed");
      $finish;
    end
  end

  // Directed table: request, take, address, left, right, length, play.
  typedef struct {
    logic [2:0] req; logic take; logic [19:0] addr;
    logic [15:0] sl; logic [15:0] sr; logic [20:0] tlen; logic pon;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_WRITE,     0, 0,       16'h7FFF, 16'h8000, 0,    0},
    '{REQ_WRITE,     0, 1,       16'h8000, 16'h7FFF, 0,    0},
    '{REQ_WRITE,     0, 2,       16'h0001, 16'hFFFF, 0,    0},
    '{REQ_WRITE,     0, 20'hFFFFF, 16'h1234, 16'h4321, 0,  0},
    '{REQ_WRITE,     1, 0,       16'h4000, 16'hC000, 0,    0},
    '{REQ_WRITE,     1, 1,       16'hC000, 16'h4000, 0,    0},
    '{REQ_PUBLISH,   0, 0,       0,       0,       0,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_PUBLISH,   0, 0,       0,       0,       3,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_TRANSPORT, 0, 0,       0,       0,       0,      1},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_PUBLISH,   1, 0,       0,       0,       2,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_REWIND,    0, 0,       0,       0,       0,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{3'd5,          1, 7,       16'hFFFF, 16'hFFFF, 21'h1FFFFF, 1},
    '{3'd7,          0, 0,       0,       0,       0,      0},
    '{REQ_TRANSPORT, 0, 0,       0,       0,       0,      0},
    '{REQ_TICK,      0, 0,       0,       0,       0,      0},
    '{REQ_TICK,      1, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 21'h1FFFFF, 1}
  };

  initial begin
    logic [19:0] rates [5];
    logic [15:0] ramps [4];
    logic [15:0] fades [4];
    int unsigned phase;
    rates = '{20'd65536, 20'd0, 20'hFFFFF, 20'd40000, 20'd98304};
    ramps = '{16'd1, 16'd32768, 16'd4000, 16'd0};
    fades = '{16'd1, 16'd65535, 16'd3, 16'd0};
    player_reset();
    written_top = '{0, 0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part; the first tick with nothing published is all zero.
    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].take, directed[i].addr, directed[i].sl,
                   directed[i].sr, directed[i].tlen, directed[i].pon);
      if (i == 0 && frames_due.size() != 0 && frames_due[0] !== '0) begin
        mismatches++;
        $display("empty take must give a zero frame");
      end
    end
    // The published lengths need only the written frames 0..2 of take 0 and 0..1 of take 1.
    written_top[0] = (written_top[0] < 3) ? 3 : written_top[0];
    written_top[1] = (written_top[1] < 2) ? 2 : written_top[1];

    // Random phases over register settings and idle patterns.
    for (phase = 0; phase < 8; phase++) begin
      write_reg(CFG_RATE, rates[phase % 5]);
      write_reg(CFG_RAMP, ramps[phase % 4]);
      write_reg(CFG_FADE, fades[(phase / 2) % 4]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      fill_take(0, 8 + phase * 4);
      fill_take(1, 6 + phase * 3);
      send_request(REQ_PUBLISH, phase[0], '0, '0, '0, 21'(written_top[phase[0]]), 0);
      send_request(REQ_TRANSPORT, 0, '0, '0, '0, '0, 1);
      for (int k = 0; k < 95; k++) begin
        random_request();
        if (phase == 3 && k == 40) drain();
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();

    if (mismatches == 0 && frames_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/lspc_pkg.sv
design/loop_sample_player_crossfade.sv
test/tb_top.sv
